// File: rtl/dan_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dan_pkg;

    // calendar limits
    localparam int unsigned YEAR_MIN = 1;
    localparam int unsigned YEAR_MAX = 9999;
    localparam int unsigned DAYS_COMMON_YEAR = 365;

    // year / 100 as a multiply by a reciprocal, exact for any 14-bit year
    localparam int unsigned RECIP_100 = 5243;
    localparam int unsigned RECIP_SHIFT = 19;

    // status codes
    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_BAD_DATE = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // month lengths, index 0 is not a month
    localparam logic [4:0] MONTH_LEN [0:12] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };
    localparam logic [4:0] MONTH_LEN_LEAP [0:12] = '{
        5'd0, 5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // running residues of the current year: year % 100 and (year / 100) % 4
    typedef struct packed {
        logic [6:0] c100;
        logic [1:0] q4;
    } yr_mod_t;

    // calendar facts about the current and the previous year
    typedef struct packed {
        logic       leap_cur;
        logic [8:0] len_cur;
        logic [8:0] len_prev;
    } cal_info_t;

endpackage

`default_nettype wire

// File: rtl/dan_cal.sv
`timescale 1ns / 1ps
`default_nettype none

module dan_cal
    import dan_pkg::*;
(
    input  wire logic [1:0] year_lo,
    input  wire yr_mod_t    ymod,
    input  wire logic [3:0] month,
    output cal_info_t       info,
    output logic [4:0]      mdays
);

    logic       leap_cur;
    logic       leap_prev;
    logic [1:0] prev_lo;
    logic [6:0] prev_c100;
    logic [1:0] prev_q4;

    // residues of the year before
    always_comb
    begin
        prev_lo = year_lo - 2'd1;
        if (ymod.c100 == 7'd0)
        begin
            prev_c100 = 7'd99;
            prev_q4 = ymod.q4 - 2'd1;
        end
        else
        begin
            prev_c100 = ymod.c100 - 7'd1;
            prev_q4 = ymod.q4;
        end
    end

    // 4/100/400 rule on the residues
    assign leap_cur = ((year_lo == 2'd0) && (ymod.c100 != 7'd0))
                      || ((ymod.c100 == 7'd0) && (ymod.q4 == 2'd0));
    assign leap_prev = ((prev_lo == 2'd0) && (prev_c100 != 7'd0))
                       || ((prev_c100 == 7'd0) && (prev_q4 == 2'd0));

    assign info.leap_cur = leap_cur;
    assign info.len_cur = 9'(DAYS_COMMON_YEAR) + {8'd0, leap_cur};
    assign info.len_prev = 9'(DAYS_COMMON_YEAR) + {8'd0, leap_prev};

    // month length lookup, zero for a code that is not a month
    always_comb
    begin
        if ((month == 4'd0) || (month > 4'd12))
            mdays = 5'd0;
        else if (leap_cur)
            mdays = MONTH_LEN_LEAP[month];
        else
            mdays = MONTH_LEN[month];
    end

endmodule

`default_nettype wire

// File: rtl/date_add_days_normalizer.sv
`timescale 1ns / 1ps
`default_nettype none

// Adds a signed day offset to a Gregorian date and returns the normalized date
// with a status (ok, invalid input date, result outside years 1..9999); on
// either error the input date is returned unchanged. One transaction is worked
// on at a time by a single shared adder under a small sequencer: setup steps
// (accept, year/100 split, residue, date check), then a walk over the months
// before the start month for the day of year, the offset add, a walk over the
// years crossed (about |offset|/365 years, so up to about 180 at 17 offset
// bits) plus a closing year test, a walk over the months up to the result
// month and a final load of the output register. A bad input date goes from
// the date check straight to the output load; an out-of-range result stops
// when a year step would pass the limit. in_stall is high while a transaction
// is at work; a finished result waits in the output register while the next
// one runs.

module date_add_days_normalizer
    import dan_pkg::*;
#(
    parameter int OFFSET_BITS = 17
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [4:0]             in_day,
    input  wire logic [3:0]             in_month,
    input  wire logic [13:0]            in_year,
    input  wire logic [OFFSET_BITS-1:0] day_offset,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [4:0]                  out_day,
    output logic [3:0]                  out_month,
    output logic [13:0]                 out_year,
    output logic [1:0]                  status
);

    localparam int RW = ((OFFSET_BITS > 11) ? OFFSET_BITS : 11) + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_REM   = 4'd2;
    localparam logic [3:0] S_CHECK = 4'd3;
    localparam logic [3:0] S_DOY   = 4'd4;
    localparam logic [3:0] S_ADD   = 4'd5;
    localparam logic [3:0] S_YEAR  = 4'd6;
    localparam logic [3:0] S_MON   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]             state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;

    logic [4:0]             day_reg;
    logic [3:0]             month_reg;
    logic [13:0]            year_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [7:0]             q_reg, q_next;
    yr_mod_t                ymod_reg, ymod_next;
    logic [13:0]            cur_year_reg, cur_year_next;
    logic signed [RW-1:0]   r_reg, r_next;
    logic [3:0]             mon_reg, mon_next;
    logic [4:0]             res_day_reg, res_day_next;
    logic [3:0]             res_month_reg, res_month_next;
    logic [13:0]            res_year_reg, res_year_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic [4:0]             out_day_reg;
    logic [3:0]             out_month_reg;
    logic [13:0]            out_year_reg;
    logic [1:0]             status_reg;

    logic                   accept;
    logic                   out_free;
    logic [26:0]            recip_prod;
    logic [13:0]            rem100;
    logic [3:0]             cal_month;
    cal_info_t              cal;
    logic [4:0]             mdays;
    logic signed [RW-1:0]   addend;
    logic signed [RW-1:0]   sum;
    logic signed [RW-1:0]   mdays_ext;
    logic signed [RW-1:0]   len_cur_ext;
    logic signed [RW-1:0]   len_prev_ext;
    logic signed [RW-1:0]   off_ext;
    logic signed [RW-1:0]   day0_ext;
    logic                   date_ok;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    // year split: q = year / 100, then residue year % 100
    assign recip_prod = {13'd0, year_reg} * 27'(RECIP_100);
    assign rem100 = year_reg - 14'({6'd0, q_reg} * 14'd100);

    // calendar lookups for the year being stepped
    assign cal_month = (state_reg == S_CHECK) ? month_reg : mon_reg;

    dan_cal u_cal (
        .year_lo (cur_year_reg[1:0]),
        .ymod    (ymod_reg),
        .month   (cal_month),
        .info    (cal),
        .mdays   (mdays)
    );

    assign mdays_ext = $signed({{(RW-5){1'b0}}, mdays});
    assign len_cur_ext = $signed({{(RW-9){1'b0}}, cal.len_cur});
    assign len_prev_ext = $signed({{(RW-9){1'b0}}, cal.len_prev});
    assign off_ext = $signed({{(RW-OFFSET_BITS){off_reg[OFFSET_BITS-1]}}, off_reg});
    assign day0_ext = $signed({{(RW-5){1'b0}}, day_reg - 5'd1});

    assign date_ok = (month_reg >= 4'd1) && (month_reg <= 4'd12)
                     && (year_reg >= 14'(YEAR_MIN)) && (year_reg <= 14'(YEAR_MAX))
                     && (day_reg >= 5'd1) && (day_reg <= mdays);

    // shared adder operand select
    always_comb
    begin
        case (state_reg)
            S_DOY:   addend = mdays_ext;
            S_ADD:   addend = off_ext;
            S_YEAR:  addend = r_reg[RW-1] ? len_prev_ext : -len_cur_ext;
            S_MON:   addend = -mdays_ext;
            default: addend = '0;
        endcase
    end

    assign sum = r_reg + addend;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_next = q_reg;
        ymod_next = ymod_reg;
        cur_year_next = cur_year_reg;
        r_next = r_reg;
        mon_next = mon_reg;
        res_day_next = res_day_reg;
        res_month_next = res_month_reg;
        res_year_next = res_year_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                q_next = recip_prod[RECIP_SHIFT+7:RECIP_SHIFT];
                cur_year_next = year_reg;
                state_next = S_REM;
            end
            S_REM:
            begin
                ymod_next.c100 = rem100[6:0];
                ymod_next.q4 = q_reg[1:0];
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                res_day_next = day_reg;
                res_month_next = month_reg;
                res_year_next = year_reg;
                if (date_ok)
                begin
                    r_next = day0_ext;
                    mon_next = 4'd1;
                    state_next = S_DOY;
                end
                else
                begin
                    res_status_next = STATUS_BAD_DATE;
                    state_next = S_DONE;
                end
            end
            S_DOY:
            begin
                if (mon_reg == month_reg)
                    state_next = S_ADD;
                else
                begin
                    r_next = sum;
                    mon_next = mon_reg + 4'd1;
                end
            end
            S_ADD:
            begin
                r_next = sum;
                state_next = S_YEAR;
            end
            S_YEAR:
            begin
                if (r_reg[RW-1])
                begin
                    // borrow a whole year
                    if (cur_year_reg == 14'(YEAR_MIN))
                    begin
                        res_status_next = STATUS_RANGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        r_next = sum;
                        cur_year_next = cur_year_reg - 14'd1;
                        if (ymod_reg.c100 == 7'd0)
                        begin
                            ymod_next.c100 = 7'd99;
                            ymod_next.q4 = ymod_reg.q4 - 2'd1;
                        end
                        else
                            ymod_next.c100 = ymod_reg.c100 - 7'd1;
                    end
                end
                else if (!sum[RW-1])
                begin
                    // carry a whole year
                    if (cur_year_reg == 14'(YEAR_MAX))
                    begin
                        res_status_next = STATUS_RANGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        r_next = sum;
                        cur_year_next = cur_year_reg + 14'd1;
                        if (ymod_reg.c100 == 7'd99)
                        begin
                            ymod_next.c100 = 7'd0;
                            ymod_next.q4 = ymod_reg.q4 + 2'd1;
                        end
                        else
                            ymod_next.c100 = ymod_reg.c100 + 7'd1;
                    end
                end
                else
                begin
                    mon_next = 4'd1;
                    state_next = S_MON;
                end
            end
            S_MON:
            begin
                if (!sum[RW-1] && (mon_reg != 4'd12))
                begin
                    r_next = sum;
                    mon_next = mon_reg + 4'd1;
                end
                else
                begin
                    res_day_next = r_reg[4:0] + 5'd1;
                    res_month_next = mon_reg;
                    res_year_next = cur_year_reg;
                    res_status_next = STATUS_OK;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            day_reg <= in_day;
            month_reg <= in_month;
            year_reg <= in_year;
            off_reg <= day_offset;
        end
        q_reg <= q_next;
        ymod_reg <= ymod_next;
        cur_year_reg <= cur_year_next;
        r_reg <= r_next;
        mon_reg <= mon_next;
        res_day_reg <= res_day_next;
        res_month_reg <= res_month_next;
        res_year_reg <= res_year_next;
        res_status_reg <= res_status_next;
        if ((state_reg == S_DONE) && out_free)
        begin
            out_day_reg <= res_day_reg;
            out_month_reg <= res_month_reg;
            out_year_reg <= res_year_reg;
            status_reg <= res_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_day = out_day_reg;
    assign out_month = out_month_reg;
    assign out_year = out_year_reg;
    assign status = status_reg;

endmodule

`default_nettype wire

// File: verif/date_add_days_checker.sv
`timescale 1ns / 1ps

module date_add_days_checker
    import dan_pkg::*;
#(
    parameter int OFFSET_BITS = 17
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [4:0]             in_day,
    input  logic [3:0]             in_month,
    input  logic [13:0]            in_year,
    input  logic [OFFSET_BITS-1:0] day_offset,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [4:0]             out_day,
    input  logic [3:0]             out_month,
    input  logic [13:0]            out_year,
    input  logic [1:0]             status,
    output int                     fail_count,
    output int                     pending,
    output int                     ok_count,
    output int                     bad_count,
    output int                     range_count
);

    typedef struct {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [1:0]  status;
    } date_result_t;

    // dates still owed by the block, oldest first
    date_result_t expected_dates[$];

    // gregorian leap rule
    function automatic bit is_leap_year(int y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int month_days(int m, int y);
        if (m < 1 || m > 12)
        begin
            return 0;
        end
        return is_leap_year(y) ? int'(MONTH_LEN_LEAP[m]) : int'(MONTH_LEN[m]);
    endfunction

    // days from the start of year 1 to the start of year y
    function automatic int year_start(int y);
        int p;
        p = y - 1;
        return p * 365 + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic int day_number(int d, int m, int y);
        int n;
        n = year_start(y);
        for (int i = 1; i < m; i++)
        begin
            n += month_days(i, y);
        end
        return n + d - 1;
    endfunction

    // expected outcome of one transaction
    function automatic date_result_t shift_date(logic [4:0] d, logic [3:0] m,
                                                logic [13:0] y,
                                                logic [OFFSET_BITS-1:0] off);
        date_result_t res;
        int dd;
        int mm;
        int yy;
        int delta;
        int serial;
        int rem;
        dd = int'(d);
        mm = int'(m);
        yy = int'(y);
        delta = int'($signed(off));
        res.day = d;
        res.month = m;
        res.year = y;
        res.status = STATUS_BAD_DATE;
        if (mm < 1 || mm > 12 || yy < int'(YEAR_MIN) || yy > int'(YEAR_MAX) || dd < 1
            || dd > month_days(mm, yy))
        begin
            return res;
        end
        serial = day_number(dd, mm, yy) + delta;
        if (serial < 0 || serial > day_number(31, 12, int'(YEAR_MAX)))
        begin
            res.status = STATUS_RANGE;
            return res;
        end
        // year from a low estimate, then step up
        yy = serial / 366 + 1;
        while (year_start(yy + 1) <= serial)
        begin
            yy++;
        end
        rem = serial - year_start(yy);
        mm = 1;
        while (rem >= month_days(mm, yy))
        begin
            rem -= month_days(mm, yy);
            mm++;
        end
        res.day = 5'(rem + 1);
        res.month = 4'(mm);
        res.year = 14'(yy);
        res.status = STATUS_OK;
        return res;
    endfunction

    // watch both channels, results first so a same-cycle input never matches
    always @(posedge clk)
    begin : watch
        date_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_dates.size() == 0)
                begin
                    $error("result with no transaction waiting: %0d-%0d-%0d status %0d",
                           out_year, out_month, out_day, status);
                    fail_count++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (out_day !== want.day)
                    begin
                        $error("out_day mismatch: expected %0d, actual %0d",
                               want.day, out_day);
                        fail_count++;
                    end
                    if (out_month !== want.month)
                    begin
                        $error("out_month mismatch: expected %0d, actual %0d",
                               want.month, out_month);
                        fail_count++;
                    end
                    if (out_year !== want.year)
                    begin
                        $error("out_year mismatch: expected %0d, actual %0d",
                               want.year, out_year);
                        fail_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, status);
                        fail_count++;
                    end
                    case (want.status)
                        STATUS_OK:       ok_count++;
                        STATUS_BAD_DATE: bad_count++;
                        default:         range_count++;
                    endcase
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_dates.push_back(shift_date(in_day, in_month, in_year, day_offset));
            end
            pending = expected_dates.size();
        end
    end

endmodule

// File: verif/tb_date_add_days_normalizer.sv
`timescale 1ns / 1ps

module tb_date_add_days_normalizer;

    localparam int OFFSET_BITS = 17;
    localparam int RANDOM_ITEMS = 450;
    localparam int DIRECTED_ITEMS = 24;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 300;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {1'b0, {(OFFSET_BITS-1){1'b1}}};
    localparam logic [OFFSET_BITS-1:0] OFFSET_MIN = {1'b1, {(OFFSET_BITS-1){1'b0}}};

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [4:0]             in_day = '0;
    logic [3:0]             in_month = '0;
    logic [13:0]            in_year = '0;
    logic [OFFSET_BITS-1:0] day_offset = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [4:0]             out_day;
    logic [3:0]             out_month;
    logic [13:0]            out_year;
    logic [1:0]             status;

    int fail_count;
    int pending;
    int ok_count;
    int bad_count;
    int range_count;
    int sent_count;
    bit no_gaps;
    bit hold_request;

    date_add_days_normalizer #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_day     (in_day),
        .in_month   (in_month),
        .in_year    (in_year),
        .day_offset (day_offset),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_day    (out_day),
        .out_month  (out_month),
        .out_year   (out_year),
        .status     (status)
    );

    date_add_days_checker #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_day      (in_day),
        .in_month    (in_month),
        .in_year     (in_year),
        .day_offset  (day_offset),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_day     (out_day),
        .out_month   (out_month),
        .out_year    (out_year),
        .status      (status),
        .fail_count  (fail_count),
        .pending     (pending),
        .ok_count    (ok_count),
        .bad_count   (bad_count),
        .range_count (range_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #1_500_000;
        $display("*** FAILED ***");
        $finish;
    end

    // signed day count as an offset field
    function automatic logic [OFFSET_BITS-1:0] off_days(int n);
        return OFFSET_BITS'(n);
    endfunction

    // offer one transaction, with random gaps ahead of it
    task automatic offer_date(input logic [4:0] d, input logic [3:0] m,
                              input logic [13:0] y, input logic [OFFSET_BITS-1:0] off);
        while (!no_gaps && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_day <= d;
        in_month <= m;
        in_year <= y;
        day_offset <= off;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sent_count++;
    endtask

    // mostly valid dates, some near interesting years, some broken ones
    task automatic pick_random(output logic [4:0] d, output logic [3:0] m,
                               output logic [13:0] y, output logic [OFFSET_BITS-1:0] off);
        int span;
        case ($urandom_range(0, 9))
            0:       y = 14'($urandom_range(1, 3));
            1:       y = 14'($urandom_range(9997, 9999));
            2:       y = 14'($urandom_range(1, 99) * 100);
            3:       y = 14'($urandom_range(1, 24) * 400);
            default: y = 14'($urandom_range(1, 9999));
        endcase
        m = 4'($urandom_range(1, 12));
        d = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(1, 28))
                                       : 5'($urandom_range(29, 31));
        case ($urandom_range(0, 5))
            0:       off = off_days(int'($urandom_range(0, 800)) - 400);
            1:       off = ($urandom_range(0, 1) != 0) ? OFFSET_MAX : OFFSET_MIN;
            2:
            begin
                span = int'($urandom_range(0, 180)) * 365;
                off = ($urandom_range(0, 1) != 0) ? off_days(-span) : off_days(span);
            end
            default: off = OFFSET_BITS'($urandom);
        endcase
        // broken date: one field forced out of its valid range
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 2))
                0:       d = 5'd0;
                1:       m = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
                default: y = 14'd0;
            endcase
        end
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin : receiver
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_stall <= !no_gaps && $urandom_range(0, 99) < 16;
            end
        end
    end

    // reset, stimulus and verdict
    initial
    begin : stimulus
        logic [4:0]             d;
        logic [3:0]             m;
        logic [13:0]            y;
        logic [OFFSET_BITS-1:0] off;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: calendar edges, leap rules, offset extremes, bad dates
        offer_date(5'd1, 4'd1, 14'd1, off_days(0));
        offer_date(5'd1, 4'd1, 14'd1, off_days(-1));
        offer_date(5'd31, 4'd12, 14'd9999, off_days(0));
        offer_date(5'd31, 4'd12, 14'd9999, off_days(1));
        offer_date(5'd31, 4'd12, 14'd9999, OFFSET_MIN);
        offer_date(5'd1, 4'd1, 14'd1, OFFSET_MAX);
        offer_date(5'd15, 4'd6, 14'd5000, OFFSET_MAX);
        offer_date(5'd15, 4'd6, 14'd5000, OFFSET_MIN);
        offer_date(5'd1, 4'd1, 14'd100, OFFSET_MIN);
        offer_date(5'd29, 4'd2, 14'd2000, off_days(0));
        offer_date(5'd29, 4'd2, 14'd1900, off_days(0));
        offer_date(5'd29, 4'd2, 14'd2024, off_days(365));
        offer_date(5'd28, 4'd2, 14'd2023, off_days(1));
        offer_date(5'd1, 4'd3, 14'd2024, off_days(-1));
        offer_date(5'd1, 4'd3, 14'd2100, off_days(-1));
        offer_date(5'd31, 4'd1, 14'd2023, off_days(29));
        offer_date(5'd31, 4'd4, 14'd2023, off_days(1));
        offer_date(5'd0, 4'd5, 14'd2023, off_days(1));
        offer_date(5'd31, 4'd0, 14'd2023, off_days(1));
        offer_date(5'd31, 4'd13, 14'd2023, off_days(1));
        offer_date(5'd31, 4'd15, 14'd8191, off_days(-1));
        offer_date(5'd1, 4'd1, 14'd0, off_days(1));
        offer_date(5'd31, 4'd12, 14'd10000 - 14'd1, off_days(-3652058 % 65536));
        offer_date(5'd30, 4'd11, 14'd8191, off_days(31));

        // random part, with a gap-free stretch and one long receiver hold-off
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_gaps = (i >= 300 && i < 380);
            if (i == 150)
            begin
                hold_request = 1'b1;
            end
            pick_random(d, m, y, off);
            offer_date(d, m, y, off);
        end
        in_valid <= 1'b0;
        no_gaps = 1'b0;

        // let the checker record the last transaction, then drain
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transactions (%0d directed, %0d random) with stalls on both sides",
                 sent_count, DIRECTED_ITEMS, RANDOM_ITEMS);
        $display("results: %0d shifted dates, %0d bad input dates, %0d out of year range",
                 ok_count, bad_count, range_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
